/* hdl/pixel_row_fill_and_read_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the pixel row fill and read core
// Clocked assertion shorthands with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef PIXEL_ROW_FILL_AND_READ_CORE_DEFINES_SVH
`define PIXEL_ROW_FILL_AND_READ_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define PRFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, disabled while in reset
`define PRFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

/* hdl/prfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfr_pkg
// Types, register indexes, opcodes and byte lane helper for the frame store.
// ----------------------------------------------------------------------------
package prfr_pkg;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 9;

	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_SIZE   = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MSB_FIRST    = 4'd3;

	localparam logic OP_FILL = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [1:0] SIZE_24 = 2'd2;

	typedef struct packed {
		logic               op;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic        [31:0] pixel_value;
		logic        [15:0] run_length;
	} prfr_cmd_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic        in_frame;
	} prfr_result_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PITCH,
		ST_MUL,
		ST_BASE,
		ST_FILL,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_DONE
	} prfr_state_t;

	// Bit offset of byte lane k (first in memory is lane 0) within a pixel
	function automatic logic [4:0] lane_shift(input logic [1:0] size_code,
		input logic msb_first, input logic [1:0] lane);
		logic [1:0] k;
		k = lane;
		if (size_code == SIZE_24 && msb_first) begin
			k = 2'd2 - lane;
		end
		return {k, 3'b000};
	endfunction

endpackage

/* hdl/pixel_row_fill_and_read_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_row_fill_and_read_core
// Byte-addressed frame store with row fill and single pixel read.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------
//  command  | start / busy       | cmd    (op, pos_x, pos_y, value, run)
//  result   | done (1-cycle)     | result (read_value, in_frame)
//  config   | cfg_we             | cfg_index, cfg_data
//
// A command is taken when start is high and busy is low; busy stays high
// through the result strobe. An outside position goes straight to done; a read
// fetches the pixel's bytes and a fill writes those of each clipped-run pixel,
// one at a time through the single byte port of the frame memory. After reset
// the memory is swept to zero, one byte per cycle, over STORE_BYTES bytes with
// busy high. The result is shown for one cycle only; there is no back-pressure.
// ----------------------------------------------------------------------------
`include "pixel_row_fill_and_read_core_defines.svh"

module pixel_row_fill_and_read_core
	import prfr_pkg::*;
#(
	parameter int MAX_WIDTH   = 256,
	parameter int MAX_HEIGHT  = 64,
	parameter int STORE_BYTES = 65536
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  prfr_cmd_t              cmd,
	output logic                   done,
	output prfr_result_t           result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int ADDR_W = $clog2(STORE_BYTES);
	localparam int CALC_W = (ADDR_W > 19) ? ADDR_W + 1 : 20;

	prfr_state_t state_q, state_d;

	logic [8:0]        cfg_width_q;
	logic [6:0]        cfg_height_q;
	logic [1:0]        cfg_size_q;
	logic              cfg_be_q;

	logic [ADDR_W-1:0] clr_q;
	logic              op_q;
	logic              inside_q;
	logic [8:0]        x_q;
	logic [6:0]        y_q;
	logic [31:0]       pix_q;
	logic [15:0]       run_q;
	logic [8:0]        len_q;
	logic [10:0]       pitch_q;
	logic [CALC_W-1:0] prod_q;
	logic [CALC_W-1:0] addr_q;
	logic [1:0]        lane_q;
	logic [31:0]       val_q;

	logic [8:0]        w_eff;
	logic [6:0]        h_eff;
	logic [2:0]        nb;
	logic              inside_now;
	logic [9:0]        room;
	logic [CALC_W-1:0] add_a, add_b, add_sum;
	logic              addr_ok;
	logic              lane_last;
	logic [4:0]        shift;
	logic [7:0]        fill_byte;
	logic [7:0]        rd_data;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic              accept;

	// Effective geometry
	always_comb begin
		if (32'(cfg_width_q) < MAX_WIDTH) begin
			w_eff = cfg_width_q;
		end else begin
			w_eff = 9'(MAX_WIDTH);
		end
		if (32'(cfg_height_q) < MAX_HEIGHT) begin
			h_eff = cfg_height_q;
		end else begin
			h_eff = 7'(MAX_HEIGHT);
		end
	end

	assign nb         = {1'b0, cfg_size_q} + 3'd1;
	assign inside_now = !cmd.pos_x[15] && !cmd.pos_y[15]
		&& ($unsigned(cmd.pos_x) < {7'd0, w_eff})
		&& ($unsigned(cmd.pos_y) < {9'd0, h_eff});
	assign room       = {1'b0, w_eff} - {1'b0, x_q};
	assign addr_ok    = addr_q < CALC_W'(STORE_BYTES);
	assign lane_last  = lane_q == cfg_size_q;
	assign shift      = lane_shift(cfg_size_q, cfg_be_q, lane_q);
	assign fill_byte  = 8'(pix_q >> shift);

	// Shared address adder: base offset once, then one byte step for each byte filled or read
	always_comb begin
		if (state_q == ST_BASE) begin
			add_a = prod_q;
			add_b = CALC_W'(x_q * nb);
		end else begin
			add_a = addr_q;
			add_b = CALC_W'(1);
		end
		add_sum = add_a + add_b;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_W'(STORE_BYTES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = inside_now ? ST_PITCH : ST_DONE;
				end
			end
			ST_PITCH: state_d = ST_MUL;
			ST_MUL:   state_d = ST_BASE;
			ST_BASE: begin
				if (op_q == OP_READ) begin
					state_d = ST_RD_ADDR;
				end else if (len_q == 9'd0) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (lane_last && len_q == 9'd1) begin
					state_d = ST_DONE;
				end
			end
			ST_RD_ADDR: state_d = ST_RD_DATA;
			ST_RD_DATA: state_d = lane_last ? ST_DONE : ST_RD_ADDR;
			ST_DONE:    state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Outputs and memory write port
	always_comb begin
		busy      = 1'b1;
		done      = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = addr_q[ADDR_W-1:0];
		ram_wdata = fill_byte;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = 8'd0;
			end
			ST_IDLE: busy = 1'b0;
			ST_FILL: ram_we = addr_ok;
			ST_DONE: done = 1'b1;
			default: ;
		endcase
	end

	assign accept            = start && !busy;
	assign result.read_value = val_q;
	assign result.in_frame   = inside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			cfg_width_q  <= 9'd256;
			cfg_height_q <= 7'd64;
			cfg_size_q   <= 2'd3;
			cfg_be_q     <= 1'b0;
			op_q         <= OP_FILL;
			inside_q     <= 1'b0;
			len_q        <= '0;
			lane_q       <= '0;
			addr_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_FRAME_WIDTH:  cfg_width_q  <= cfg_data;
					CFG_FRAME_HEIGHT: cfg_height_q <= cfg_data[6:0];
					CFG_PIXEL_SIZE:   cfg_size_q   <= cfg_data[1:0];
					CFG_MSB_FIRST:    cfg_be_q     <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + ADDR_W'(1);
				ST_IDLE: begin
					if (accept) begin
						op_q     <= cmd.op;
						inside_q <= inside_now;
					end
				end
				ST_PITCH: begin
					// clip the run at the right edge
					if (run_q > {6'd0, room}) begin
						len_q <= room[8:0];
					end else begin
						len_q <= run_q[8:0];
					end
				end
				ST_BASE: begin
					addr_q <= add_sum;
					lane_q <= 2'd0;
				end
				ST_FILL: begin
					addr_q <= add_sum;
					if (lane_last) begin
						lane_q <= 2'd0;
						len_q  <= len_q - 9'd1;
					end else begin
						lane_q <= lane_q + 2'd1;
					end
				end
				ST_RD_DATA: begin
					addr_q <= add_sum;
					lane_q <= lane_q + 2'd1;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= cmd.pos_x[8:0];
			y_q   <= cmd.pos_y[6:0];
			pix_q <= cmd.pixel_value;
			run_q <= cmd.run_length;
			val_q <= 32'd0;
		end
		if (state_q == ST_PITCH) begin
			pitch_q <= 11'(w_eff * nb);
		end
		if (state_q == ST_MUL) begin
			prod_q <= CALC_W'(y_q * pitch_q);
		end
		if (state_q == ST_RD_DATA && addr_ok) begin
			val_q <= val_q | (32'(rd_data) << shift);
		end
	end

	prfr_byte_ram #(
		.DEPTH  (STORE_BYTES),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_q[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	`PRFR_ASSERT_NEXT(a_done_one_cycle, clk, arst_n, done, !done)
	`PRFR_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy)
	`PRFR_ASSERT_IMPL(a_miss_zero, clk, arst_n, done && !result.in_frame,
		result.read_value == 32'd0)
	`PRFR_ASSERT_IMPL(a_fill_inside, clk, arst_n, state_q == ST_FILL,
		inside_q && op_q == OP_FILL && len_q != 9'd0)
	`PRFR_ASSERT_IMPL(a_lane_range, clk, arst_n,
		state_q == ST_FILL || state_q == ST_RD_ADDR || state_q == ST_RD_DATA,
		lane_q <= cfg_size_q)

endmodule

/* hdl/prfr_byte_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfr_byte_ram
// Byte-wide frame memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module prfr_byte_ram #(
	parameter int DEPTH  = 65536,
	parameter int ADDR_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
